@@ hdl/sfth_pkg.sv @@
// ----------------------------------------------------------------------------
// SPI framed transaction host package
// Frame constants, status codes and the result record shared by the block.
// ----------------------------------------------------------------------------
package sfth_pkg;

   localparam logic [7:0] SYNC_BYTE = 8'h5A;
   localparam logic [7:0] HDR_ACK   = 8'h79;
   localparam logic [7:0] DATA_ACK  = 8'h85;
   localparam logic [7:0] NACK_BYTE = 8'h1F;
   localparam logic [7:0] CHK_SEED  = 8'hAB;
   localparam logic [7:0] HDR_POLL  = 8'h12;
   localparam logic [7:0] DATA_POLL = 8'hAB;
   localparam logic [7:0] FILL_BYTE = 8'h00;

   localparam logic [1:0] REQ_START   = 2'd0;
   localparam logic [1:0] REQ_PAYLOAD = 2'd1;
   localparam logic [1:0] REQ_MISO    = 2'd2;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_HDR_NACK = 3'd1;
   localparam logic [2:0] ST_DAT_NACK = 3'd2;
   localparam logic [2:0] ST_BAD_CHK  = 3'd3;
   localparam logic [2:0] ST_TOO_BIG  = 3'd4;
   localparam logic [2:0] ST_MISUSE   = 3'd5;

   localparam int MAX_RESULTS = 8;

   typedef struct packed {
      logic        mosi_valid;
      logic [7:0]  mosi_byte;
      logic        expects_reply;
      logic        rx_valid;
      logic [7:0]  reply_byte;
      logic        done_res;
      logic [2:0]  status;
      logic [15:0] reply_length;
   } result_type;

   function automatic result_type send_res(logic [7:0] b, logic er);
      result_type r;
      r = '0;
      r.mosi_valid    = 1'b1;
      r.mosi_byte     = b;
      r.expects_reply = er;
      return r;
   endfunction

   function automatic result_type finish_res(logic [2:0] st, logic [15:0] rl);
      result_type r;
      r = '0;
      r.done_res     = 1'b1;
      r.status       = st;
      r.reply_length = rl;
      return r;
   endfunction

endpackage

@@ hdl/spi_framed_transaction_host.sv @@
// ----------------------------------------------------------------------------
// SPI framed transaction host
// Turns start, payload and MISO items into MOSI byte slots and a final status.
// ----------------------------------------------------------------------------
// Each accepted item is decoded in the cycle it arrives and its results, up
// to eight of them, are loaded into a small result buffer that drives the rsp
// channel one result per cycle while rsp_ready is high. An item holds the
// output until all its results are taken: a start item has eight (one if a
// length is too big), the header ACK before an empty payload two, the last
// payload byte three, any other item one or none. A new item is accepted in
// the cycle the last result of the previous one is taken, so single-result
// items flow at one per cycle while rsp_ready is high, paced by the buffer.
module spi_framed_transaction_host #(
   parameter int BUF_BYTES = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_type,
   input  logic [7:0]  req_endpoint_id,
   input  logic [15:0] req_tx_length,
   input  logic [15:0] req_max_rx_length,
   input  logic [7:0]  req_payload_byte,
   input  logic [7:0]  req_miso_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_mosi_valid,
   output logic [7:0]  rsp_mosi_byte,
   output logic        rsp_expects_reply,
   output logic        rsp_rx_valid,
   output logic [7:0]  rsp_reply_byte,
   output logic        rsp_done_res,
   output logic [2:0]  rsp_status,
   output logic [15:0] rsp_reply_length,
   output logic        rsp_last
);
   import sfth_pkg::*;

   localparam logic [16:0] LenLimit = 17'(BUF_BYTES);
   localparam int IdxBits = $clog2(MAX_RESULTS);

   typedef enum logic [2:0] {
      PH_IDLE, PH_WAIT_HACK, PH_SEND, PH_WAIT_DACK, PH_LEN_LO, PH_LEN_HI, PH_RX
   } phase_type;

   phase_type            phase_ff, phase_in;
   logic [15:0]          to_send_ff, to_send_in;
   logic [15:0]          sent_ff, sent_in;
   logic [7:0]           send_chk_ff, send_chk_in;
   logic [7:0]           recv_chk_ff, recv_chk_in;
   logic [15:0]          rlen_ff, rlen_in;
   logic [15:0]          rcvd_ff, rcvd_in;
   result_type           res_ff [MAX_RESULTS];
   result_type           res_in [MAX_RESULTS];
   logic [IdxBits:0]     n_in;
   logic [IdxBits-1:0]   idx_ff, idx_in;
   logic [IdxBits-1:0]   last_idx_ff, last_idx_in;
   logic                 busy_ff, busy_in;
   logic                 req_take, rsp_take;
   logic [7:0]           hdr_chk, sc_new, rc_new;
   logic [15:0]          sent_inc, rlen_hi;
   logic                 start_big;
   result_type           cur;

   assign rsp_take  = rsp_valid && rsp_ready;
   assign rsp_valid = busy_ff;
   assign rsp_last  = (idx_ff == last_idx_ff);
   assign req_ready = !busy_ff || (rsp_ready && rsp_last);
   assign req_take  = req_valid && req_ready;

   assign cur               = res_ff[idx_ff];
   assign rsp_mosi_valid    = cur.mosi_valid;
   assign rsp_mosi_byte     = cur.mosi_byte;
   assign rsp_expects_reply = cur.expects_reply;
   assign rsp_rx_valid      = cur.rx_valid;
   assign rsp_reply_byte    = cur.reply_byte;
   assign rsp_done_res      = cur.done_res;
   assign rsp_status        = cur.status;
   assign rsp_reply_length  = cur.reply_length;

   always_comb begin
      hdr_chk = CHK_SEED ^ SYNC_BYTE ^ req_endpoint_id ^ req_tx_length[7:0]
              ^ req_tx_length[15:8] ^ req_max_rx_length[7:0] ^ req_max_rx_length[15:8];
      start_big = ({1'b0, req_tx_length} >= LenLimit)
               || ({1'b0, req_max_rx_length} >= LenLimit);
      sc_new   = send_chk_ff ^ req_payload_byte;
      rc_new   = recv_chk_ff ^ req_miso_byte;
      sent_inc = sent_ff + 16'd1;
      rlen_hi  = rlen_ff | {req_miso_byte, 8'h00};

      phase_in    = phase_ff;
      to_send_in  = to_send_ff;
      sent_in     = sent_ff;
      send_chk_in = send_chk_ff;
      recv_chk_in = recv_chk_ff;
      rlen_in     = rlen_ff;
      rcvd_in     = rcvd_ff;
      n_in        = '0;
      for (int i = 0; i < MAX_RESULTS; i++) begin
         res_in[i] = '0;
      end

      if (phase_ff == PH_IDLE && req_type == REQ_START) begin
         if (start_big) begin
            res_in[0] = finish_res(ST_TOO_BIG, 16'd0);
            n_in      = (IdxBits+1)'(1);
         end else begin
            res_in[0] = send_res(SYNC_BYTE, 1'b0);
            res_in[1] = send_res(req_endpoint_id, 1'b0);
            res_in[2] = send_res(req_tx_length[7:0], 1'b0);
            res_in[3] = send_res(req_tx_length[15:8], 1'b0);
            res_in[4] = send_res(req_max_rx_length[7:0], 1'b0);
            res_in[5] = send_res(req_max_rx_length[15:8], 1'b0);
            res_in[6] = send_res(hdr_chk, 1'b0);
            res_in[7] = send_res(HDR_POLL, 1'b1);
            n_in        = (IdxBits+1)'(MAX_RESULTS);
            to_send_in  = req_tx_length;
            sent_in     = '0;
            send_chk_in = CHK_SEED;
            recv_chk_in = CHK_SEED;
            rlen_in     = '0;
            rcvd_in     = '0;
            phase_in    = PH_WAIT_HACK;
         end
      end else if (phase_ff == PH_WAIT_HACK && req_type == REQ_MISO) begin
         if (req_miso_byte == HDR_ACK) begin
            if (to_send_ff == 16'd0) begin
               res_in[0] = send_res(send_chk_ff, 1'b0);
               res_in[1] = send_res(DATA_POLL, 1'b1);
               n_in      = (IdxBits+1)'(2);
               phase_in  = PH_WAIT_DACK;
            end else begin
               phase_in = PH_SEND;
            end
         end else if (req_miso_byte == NACK_BYTE) begin
            res_in[0] = finish_res(ST_HDR_NACK, 16'd0);
            n_in      = (IdxBits+1)'(1);
            phase_in  = PH_IDLE;
         end else begin
            res_in[0] = send_res(HDR_POLL, 1'b1);
            n_in      = (IdxBits+1)'(1);
         end
      end else if (phase_ff == PH_SEND && req_type == REQ_PAYLOAD) begin
         res_in[0]   = send_res(req_payload_byte, 1'b0);
         send_chk_in = sc_new;
         sent_in     = sent_inc;
         n_in        = (IdxBits+1)'(1);
         if (sent_inc >= to_send_ff) begin
            res_in[1] = send_res(sc_new, 1'b0);
            res_in[2] = send_res(DATA_POLL, 1'b1);
            n_in      = (IdxBits+1)'(3);
            phase_in  = PH_WAIT_DACK;
         end
      end else if (phase_ff == PH_WAIT_DACK && req_type == REQ_MISO) begin
         if (req_miso_byte == DATA_ACK) begin
            recv_chk_in = CHK_SEED ^ req_miso_byte;
            res_in[0]   = send_res(FILL_BYTE, 1'b1);
            n_in        = (IdxBits+1)'(1);
            phase_in    = PH_LEN_LO;
         end else if (req_miso_byte == NACK_BYTE) begin
            res_in[0] = finish_res(ST_DAT_NACK, 16'd0);
            n_in      = (IdxBits+1)'(1);
            phase_in  = PH_IDLE;
         end else begin
            res_in[0] = send_res(DATA_POLL, 1'b1);
            n_in      = (IdxBits+1)'(1);
         end
      end else if (phase_ff == PH_LEN_LO && req_type == REQ_MISO) begin
         recv_chk_in = rc_new;
         rlen_in     = {8'h00, req_miso_byte};
         res_in[0]   = send_res(FILL_BYTE, 1'b1);
         n_in        = (IdxBits+1)'(1);
         phase_in    = PH_LEN_HI;
      end else if (phase_ff == PH_LEN_HI && req_type == REQ_MISO) begin
         recv_chk_in = rc_new;
         rlen_in     = rlen_hi;
         n_in        = (IdxBits+1)'(1);
         if ({1'b0, rlen_hi} >= LenLimit) begin
            res_in[0] = finish_res(ST_TOO_BIG, 16'd0);
            phase_in  = PH_IDLE;
         end else begin
            rcvd_in   = '0;
            res_in[0] = send_res(FILL_BYTE, 1'b1);
            phase_in  = PH_RX;
         end
      end else if (phase_ff == PH_RX && req_type == REQ_MISO) begin
         recv_chk_in = rc_new;
         n_in        = (IdxBits+1)'(1);
         if (rcvd_ff < rlen_ff) begin
            rcvd_in              = rcvd_ff + 16'd1;
            res_in[0]            = send_res(FILL_BYTE, 1'b1);
            res_in[0].rx_valid   = 1'b1;
            res_in[0].reply_byte = req_miso_byte;
         end else if (rc_new == 8'h00) begin
            res_in[0] = finish_res(ST_OK, rlen_ff);
            phase_in  = PH_IDLE;
         end else begin
            res_in[0] = finish_res(ST_BAD_CHK, 16'd0);
            phase_in  = PH_IDLE;
         end
      end else begin
         res_in[0] = finish_res(ST_MISUSE, 16'd0);
         n_in      = (IdxBits+1)'(1);
         phase_in  = PH_IDLE;
      end

      last_idx_in = IdxBits'(n_in - (IdxBits+1)'(1));

      if (req_take) begin
         busy_in = (n_in != '0);
         idx_in  = '0;
      end else if (rsp_take && rsp_last) begin
         busy_in = 1'b0;
         idx_in  = idx_ff;
      end else if (rsp_take) begin
         busy_in = busy_ff;
         idx_in  = idx_ff + IdxBits'(1);
      end else begin
         busy_in = busy_ff;
         idx_in  = idx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         to_send_ff  <= '0;
         sent_ff     <= '0;
         send_chk_ff <= CHK_SEED;
         recv_chk_ff <= CHK_SEED;
         rlen_ff     <= '0;
         rcvd_ff     <= '0;
         busy_ff     <= 1'b0;
         idx_ff      <= '0;
         last_idx_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
         if (req_take) begin
            phase_ff    <= phase_in;
            to_send_ff  <= to_send_in;
            sent_ff     <= sent_in;
            send_chk_ff <= send_chk_in;
            recv_chk_ff <= recv_chk_in;
            rlen_ff     <= rlen_in;
            rcvd_ff     <= rcvd_in;
            last_idx_ff <= last_idx_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         res_ff <= res_in;
      end
   end

   a_ready_only_when_free: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> (!rsp_valid || (rsp_ready && rsp_last)))
      else $error("input accepted while results are still pending");

   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_done_res) |-> rsp_last)
      else $error("done result is not the last result of its item");

   a_rx_has_slot: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_rx_valid) |-> (rsp_mosi_valid && rsp_expects_reply))
      else $error("reply byte without a request for the next slot");

   a_index_steps: assert property (@(posedge clock) disable iff (reset)
      (rsp_take && !rsp_last) |=> (rsp_valid && idx_ff == $past(idx_ff) + IdxBits'(1)))
      else $error("result index did not advance after a taken result");

endmodule
